>>> src/vrrb_pkg.sv
package vrrb_pkg;

  localparam int WORD_W  = 64;
  localparam int LEN_W   = 11;
  localparam int COUNT_W = 32;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_SMALL   = 3'd2,
    ST_DROPPED = 3'd3,
    ST_CORRUPT = 3'd4
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] word;
    logic              first_of_record;
    logic [LEN_W-1:0]  record_words;
    logic [LEN_W-1:0]  reader_limit_words;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [WORD_W-1:0]  read_word;
    logic               last_of_record;
    logic [COUNT_W-1:0] dropped_count;
  } out_item_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic first;
    logic push_fits;
    logic wr_rem_zero;
    logic wr_dropping;
    logic rd_rem_zero;
    logic ring_empty;
    logic hdr_bad;
  } dp_sts_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic wr_hdr;
    logic drop_first;
    logic emit_drop;
    logic skip_word;
    logic wr_word;
    logic emit_empty;
    logic rd_cur;
    logic hdr_reject;
    logic hdr_accept;
    logic pop_word;
  } dp_cmd_t;

endpackage

>>> src/variable_record_ring_buffer.sv
// Path from accept to result strobe: a dropped push or an empty pop is answered from S_DECODE;
// a stored push word passes S_PUSH_WORD, a continuation pop S_POP_DATA, a refused first pop
// S_POP_HDR, an accepted first pop S_POP_HDR then S_POP_DATA; ring RAM reads are registered.
// A new transfer is taken in the strobe cycle; none is taken while busy.
// out_valid is a one-cycle strobe; the receiver cannot stall it.
// Reset (rst_n, sync): pointers, counts and drop counter clear; ring RAM contents are left as-is.
module variable_record_ring_buffer #(
  parameter int RING_WORDS       = 4096,
  parameter int MAX_RECORD_WORDS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  vrrb_pkg::in_item_t  in_item,
  output logic                out_valid,
  output vrrb_pkg::out_item_t out_item
);

  vrrb_pkg::dp_sts_t sts;
  vrrb_pkg::dp_cmd_t cmd;

  vrrb_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  vrrb_dp #(
    .RING_WORDS      (RING_WORDS),
    .MAX_RECORD_WORDS(MAX_RECORD_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transfer did not start work");

  a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != vrrb_pkg::ST_OK)
      |-> (out_item.read_word == '0 && !out_item.last_of_record))
    else $error("non-ok result carries data");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results for one transfer");

endmodule

>>> src/vrrb_ram.sv
module vrrb_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/vrrb_ctrl.sv
module vrrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  vrrb_pkg::dp_sts_t sts,
  output vrrb_pkg::dp_cmd_t cmd,
  output logic              busy
);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_DECODE    = 5'b00010,
    S_PUSH_WORD = 5'b00100,
    S_POP_HDR   = 5'b01000,
    S_POP_DATA  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        if (sts.is_pop) begin
          if (!sts.rd_rem_zero) begin
            cmd.rd_cur = 1'b1;
            state_nxt  = S_POP_DATA;
          end else if (sts.ring_empty) begin
            cmd.emit_empty = 1'b1;
          end else begin
            cmd.rd_cur = 1'b1;
            state_nxt  = S_POP_HDR;
          end
        end else if (sts.first) begin
          if (sts.push_fits) begin
            cmd.wr_hdr = 1'b1;
            state_nxt  = S_PUSH_WORD;
          end else begin
            cmd.drop_first = 1'b1;
          end
        end else if (sts.wr_rem_zero) begin
          cmd.emit_drop = 1'b1;
        end else if (sts.wr_dropping) begin
          cmd.skip_word = 1'b1;
        end else begin
          state_nxt = S_PUSH_WORD;
        end
      end
      S_PUSH_WORD: begin
        cmd.wr_word = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_POP_HDR: begin
        if (sts.hdr_bad) begin
          cmd.hdr_reject = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.hdr_accept = 1'b1;
          state_nxt      = S_POP_DATA;
        end
      end
      S_POP_DATA: begin
        cmd.pop_word = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> src/vrrb_dp.sv
module vrrb_dp #(
  parameter int RING_WORDS       = 4096,
  parameter int MAX_RECORD_WORDS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vrrb_pkg::in_item_t  in_item,
  input  vrrb_pkg::dp_cmd_t   cmd,
  output vrrb_pkg::dp_sts_t   sts,
  output logic                out_valid,
  output vrrb_pkg::out_item_t out_item
);

  localparam int PTR_W = $clog2(RING_WORDS);
  localparam int LEN_W = vrrb_pkg::LEN_W;
  localparam int CW    = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(RING_WORDS - 1)) ? '0 : p + 1'b1;
  endfunction

  vrrb_pkg::in_item_t item_r;

  logic [PTR_W-1:0]             rp_r, rp_nxt;
  logic [PTR_W-1:0]             tail_r, tail_nxt;
  logic [PTR_W-1:0]             wp_r, wp_nxt;
  logic [LEN_W-1:0]             wrem_r, wrem_nxt;
  logic                         wdrop_r, wdrop_nxt;
  logic [LEN_W-1:0]             rrem_r, rrem_nxt;
  logic [vrrb_pkg::COUNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                         ov_r, ov_nxt;
  vrrb_pkg::status_t            ostat_r, ostat_nxt;
  logic [vrrb_pkg::WORD_W-1:0]  oword_r, oword_nxt;
  logic                         olast_r, olast_nxt;

  logic [PTR_W-1:0]            occ;
  logic [LEN_W-1:0]            len;
  logic [LEN_W-1:0]            hdr_len;
  logic                        hdr_small;
  logic                        hdr_corrupt;
  logic                        ram_we;
  logic [PTR_W-1:0]            ram_waddr;
  logic [vrrb_pkg::WORD_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [PTR_W-1:0]            ram_raddr;
  logic [vrrb_pkg::WORD_W-1:0] ram_rdata;

  // committed occupancy; modulo without a divider
  assign occ = tail_r - rp_r + ((tail_r < rp_r) ? PTR_W'(RING_WORDS) : '0);
  assign len = item_r.record_words;

  assign hdr_len     = ram_rdata[LEN_W-1:0];
  assign hdr_small   = (|ram_rdata[vrrb_pkg::WORD_W-1:LEN_W])
                       || (hdr_len > item_r.reader_limit_words);
  assign hdr_corrupt = (hdr_len == '0) || (CW'(hdr_len) >= CW'(occ));

  assign sts.is_pop      = (item_r.kind == vrrb_pkg::KIND_POP);
  assign sts.first       = item_r.first_of_record;
  // needs len + 1 slots out of RING_WORDS - 1 - occ
  assign sts.push_fits   = (len != '0) && (CW'(len) <= CW'(MAX_RECORD_WORDS))
                           && (CW'(len) + CW'(occ) < CW'(RING_WORDS - 1));
  assign sts.wr_rem_zero = (wrem_r == '0);
  assign sts.wr_dropping = wdrop_r;
  assign sts.rd_rem_zero = (rrem_r == '0);
  assign sts.ring_empty  = (rp_r == tail_r);
  assign sts.hdr_bad     = hdr_small || hdr_corrupt;

  assign ram_we    = cmd.wr_hdr || cmd.wr_word;
  assign ram_waddr = cmd.wr_hdr ? tail_r : wp_r;
  assign ram_wdata = cmd.wr_hdr ? vrrb_pkg::WORD_W'(len) : item_r.word;
  assign ram_re    = cmd.rd_cur || cmd.hdr_accept;
  assign ram_raddr = cmd.hdr_accept ? next_slot(rp_r) : rp_r;

  vrrb_ram #(
    .DATA_W(vrrb_pkg::WORD_W),
    .DEPTH (RING_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    rp_nxt    = rp_r;
    tail_nxt  = tail_r;
    wp_nxt    = wp_r;
    wrem_nxt  = wrem_r;
    wdrop_nxt = wdrop_r;
    rrem_nxt  = rrem_r;
    dcnt_nxt  = dcnt_r;
    ov_nxt    = 1'b0;
    ostat_nxt = ostat_r;
    oword_nxt = oword_r;
    olast_nxt = olast_r;

    if (cmd.emit_drop || cmd.drop_first || cmd.skip_word || cmd.wr_word
        || cmd.emit_empty || cmd.hdr_reject || cmd.pop_word) begin
      ov_nxt    = 1'b1;
      oword_nxt = '0;
      olast_nxt = 1'b0;
    end

    if (cmd.wr_hdr) begin
      wp_nxt    = next_slot(tail_r);
      wrem_nxt  = len;  // the first-word transfer takes one off
      wdrop_nxt = 1'b0;
    end
    if (cmd.drop_first) begin
      dcnt_nxt  = dcnt_r + 1'b1;
      wrem_nxt  = (len == '0) ? '0 : len - 1'b1;
      wdrop_nxt = (len > LEN_W'(1));
      ostat_nxt = vrrb_pkg::ST_DROPPED;
    end
    if (cmd.emit_drop) begin
      ostat_nxt = vrrb_pkg::ST_DROPPED;
    end
    if (cmd.skip_word) begin
      wrem_nxt  = wrem_r - 1'b1;
      if (wrem_r == LEN_W'(1)) begin
        wdrop_nxt = 1'b0;
      end
      ostat_nxt = vrrb_pkg::ST_DROPPED;
    end
    if (cmd.wr_word) begin
      wp_nxt   = next_slot(wp_r);
      wrem_nxt = wrem_r - 1'b1;
      if (wrem_r == LEN_W'(1)) begin
        tail_nxt = next_slot(wp_r);  // commit on the last word
      end
      ostat_nxt = vrrb_pkg::ST_OK;
    end
    if (cmd.emit_empty) begin
      ostat_nxt = vrrb_pkg::ST_EMPTY;
    end
    if (cmd.hdr_reject) begin
      ostat_nxt = hdr_small ? vrrb_pkg::ST_SMALL : vrrb_pkg::ST_CORRUPT;
    end
    if (cmd.hdr_accept) begin
      rp_nxt   = next_slot(rp_r);
      rrem_nxt = hdr_len;
    end
    if (cmd.pop_word) begin
      rp_nxt    = next_slot(rp_r);
      rrem_nxt  = rrem_r - 1'b1;
      ostat_nxt = vrrb_pkg::ST_OK;
      oword_nxt = ram_rdata;
      olast_nxt = (rrem_r == LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r    <= '0;
      tail_r  <= '0;
      wp_r    <= '0;
      wrem_r  <= '0;
      wdrop_r <= 1'b0;
      rrem_r  <= '0;
      dcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      rp_r    <= rp_nxt;
      tail_r  <= tail_nxt;
      wp_r    <= wp_nxt;
      wrem_r  <= wrem_nxt;
      wdrop_r <= wdrop_nxt;
      rrem_r  <= rrem_nxt;
      dcnt_r  <= dcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    ostat_r <= ostat_nxt;
    oword_r <= oword_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid               = ov_r;
  assign out_item.status         = ostat_r;
  assign out_item.read_word      = oword_r;
  assign out_item.last_of_record = olast_r;
  assign out_item.dropped_count  = dcnt_r;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vrrb_pkg::*;

  localparam int RING_WORDS       = 4096;
  localparam int PTR_W            = 12;
  localparam int MAX_RECORD_WORDS = 1024;
  localparam int RANDOM_ITEMS     = 700;
  localparam int TAIL_ITEMS       = 150;
  localparam int STALL_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 8;

  // Tracks ring contents and pointers, and holds the results still owed by the block.
  class ring_tracker;
    logic [WORD_W-1:0]  store [RING_WORDS];
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   tail;
    logic [PTR_W-1:0]   wr_ptr;
    int unsigned        wr_left;
    int unsigned        rd_left;
    bit                 wr_skip;
    logic [COUNT_W-1:0] drops;
    out_item_t          owed_results [$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        status_hits [5];

    function new();
      rd_ptr     = '0;
      tail       = '0;
      wr_ptr     = '0;
      wr_left    = 0;
      rd_left    = 0;
      wr_skip    = 1'b0;
      drops      = '0;
      mismatches = 0;
      checked    = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int unsigned occupancy();
      logic [PTR_W-1:0] diff;
      diff = tail - rd_ptr;
      return 32'(diff);
    endfunction

    function int unsigned free_slots();
      return RING_WORDS - 1 - occupancy();
    endfunction

    function status_t predict_push(in_item_t it);
      int unsigned len;
      len = it.record_words;
      if (it.first_of_record) begin
        wr_ptr = tail;
        if (len == 0 || len > MAX_RECORD_WORDS || len + 1 > free_slots()) begin
          drops++;
          wr_left = (len == 0) ? 0 : len - 1;
          wr_skip = (wr_left != 0);
          return ST_DROPPED;
        end
        wr_skip = 1'b0;
        store[wr_ptr] = WORD_W'(len);
        wr_ptr++;
        store[wr_ptr] = it.word;
        wr_ptr++;
        wr_left = len - 1;
        if (wr_left == 0) tail = wr_ptr;
        return ST_OK;
      end
      if (wr_left == 0) return ST_DROPPED;
      wr_left--;
      if (wr_skip) begin
        if (wr_left == 0) wr_skip = 1'b0;
        return ST_DROPPED;
      end
      store[wr_ptr] = it.word;
      wr_ptr++;
      if (wr_left == 0) tail = wr_ptr;
      return ST_OK;
    endfunction

    function status_t predict_pop(input int unsigned limit, output logic [WORD_W-1:0] data,
                                  output logic last);
      logic [WORD_W-1:0] hdr;
      data = '0;
      last = 1'b0;
      if (rd_left == 0) begin
        if (rd_ptr == tail) return ST_EMPTY;
        hdr = store[rd_ptr];
        if (hdr > limit) return ST_SMALL;
        // headers only ever hold valid lengths, so this cannot be provoked from the ports
        if (hdr == 0 || hdr + 1 > occupancy()) return ST_CORRUPT;
        rd_ptr++;
        data = store[rd_ptr];
        rd_ptr++;
        rd_left = 32'(hdr - 1);
      end else begin
        data = store[rd_ptr];
        rd_ptr++;
        rd_left--;
      end
      last = (rd_left == 0);
      return ST_OK;
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t res;
      logic [WORD_W-1:0] data;
      logic last;
      res = '0;
      if (it.kind == KIND_PUSH) begin
        res.status = predict_push(it);
      end else begin
        res.status = predict_pop(it.reader_limit_words, data, last);
        res.read_word      = data;
        res.last_of_record = last;
      end
      res.dropped_count = drops;
      owed_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        $error("result with no transfer outstanding: status %0d", got.status);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      checked++;
      status_hits[want.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.read_word !== want.read_word) begin
        $error("read_word: expected %h, got %h", want.read_word, got.read_word);
        mismatches++;
      end
      if (got.last_of_record !== want.last_of_record) begin
        $error("last_of_record: expected %b, got %b", want.last_of_record, got.last_of_record);
        mismatches++;
      end
      if (got.dropped_count !== want.dropped_count) begin
        $error("dropped_count: expected %0d, got %0d", want.dropped_count, got.dropped_count);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;

  ring_tracker tracker;
  int unsigned gen_left;
  int unsigned gap_pct;
  int unsigned sent;
  int unsigned quiet_cycles;
  bit          gaps_on;

  variable_record_ring_buffer #(
    .RING_WORDS(RING_WORDS),
    .MAX_RECORD_WORDS(MAX_RECORD_WORDS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t push_item(bit first, int unsigned len, logic [WORD_W-1:0] w);
    in_item_t it;
    it.kind               = KIND_PUSH;
    it.word               = w;
    it.first_of_record    = first;
    it.record_words       = LEN_W'(len);
    it.reader_limit_words = LEN_W'($urandom_range(0, 2047));
    return it;
  endfunction

  function automatic in_item_t pop_item(int unsigned limit);
    in_item_t it;
    it.kind               = KIND_POP;
    it.word               = rand_word();
    it.first_of_record    = 1'($urandom_range(0, 1));
    it.record_words       = LEN_W'($urandom_range(0, 2047));
    it.reader_limit_words = LEN_W'(limit);
    return it;
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 16);
    if (r < 99) return $urandom_range(17, 64);
    return $urandom_range(65, MAX_RECORD_WORDS);
  endfunction

  function automatic int unsigned pick_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return MAX_RECORD_WORDS;
    if (r < 80) return $urandom_range(0, MAX_RECORD_WORDS);
    if (r < 95) return $urandom_range(0, 15);
    return $urandom_range(MAX_RECORD_WORDS + 1, 2047);
  endfunction

  // Mostly whole records and pops; a few stray words, bad lengths and abandoned records.
  function automatic in_item_t next_random_item();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 45) return pop_item(pick_limit());
    if (r < 93) begin
      if (gen_left > 0) begin
        gen_left--;
        return push_item(1'b0, $urandom_range(0, 2047), rand_word());
      end
      len = pick_len();
      gen_left = len - 1;
      return push_item(1'b1, len, rand_word());
    end
    case ($urandom_range(0, 3))
      0: begin
        if (gen_left > 0) gen_left--;
        return push_item(1'b0, $urandom_range(0, 2047), rand_word());
      end
      1: begin
        len = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_RECORD_WORDS + 1, 2047);
        gen_left = (len == 0) ? 0 : $urandom_range(0, 4);
        return push_item(1'b1, len, rand_word());
      end
      2: begin
        len = pick_len();
        gen_left = len - 1;
        return push_item(1'b1, len, rand_word());
      end
      default: return pop_item($urandom_range(0, 3));
    endcase
  endfunction

  task automatic idle_for(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send(in_item_t it);
    if (gaps_on && $urandom_range(0, 99) < gap_pct) idle_for($urandom_range(1, 9));
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_transfer(it);
    sent++;
  endtask

  initial begin
    tracker = new();
    start   <= 1'b0;
    in_item <= '0;
    rst_n   <= 1'b0;
    gen_left = 0;
    gap_pct  = 30;
    gaps_on  = 1'b1;
    sent     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring, stray word, bad lengths, abandoned record, limits
    send(pop_item(MAX_RECORD_WORDS));
    send(push_item(1'b0, 5, '1));
    send(push_item(1'b1, 0, '1));
    send(push_item(1'b1, 2047, '1));
    send(push_item(1'b0, 0, '0));
    send(push_item(1'b1, 1, '0));
    send(pop_item(0));
    send(pop_item(1));
    send(push_item(1'b1, 3, '1));
    send(push_item(1'b0, 0, 64'ha5a5_5a5a_f00f_0ff0));
    send(push_item(1'b1, 2, 64'h5555_aaaa_5555_aaaa));
    send(pop_item(MAX_RECORD_WORDS));
    send(push_item(1'b0, 2047, '1));
    send(pop_item(1));
    send(pop_item(2));
    send(pop_item(0));
    send(pop_item(MAX_RECORD_WORDS));
    send(push_item(1'b1, MAX_RECORD_WORDS + 1, rand_word()));
    send(push_item(1'b1, MAX_RECORD_WORDS, rand_word()));
    send(push_item(1'b1, 1, '1));
    send(pop_item(MAX_RECORD_WORDS));
    send(push_item(1'b0, 1, rand_word()));

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      send(next_random_item());
    end

    gaps_on = 1'b0;
    for (int unsigned i = 0; i < TAIL_ITEMS; i++) send(next_random_item());
    start <= 1'b0;

    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d transfers, %0d results: ok %0d, empty %0d, reader too small %0d, dropped %0d",
             sent, tracker.checked, tracker.status_hits[ST_OK], tracker.status_hits[ST_EMPTY],
             tracker.status_hits[ST_SMALL], tracker.status_hits[ST_DROPPED]);
    $display("records of 1 to %0d words mixed with pops, stray words and bad lengths; %0d dropped",
             MAX_RECORD_WORDS, tracker.drops);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/vrrb_pkg.sv
src/vrrb_ram.sv
src/vrrb_ctrl.sv
src/vrrb_dp.sv
src/variable_record_ring_buffer.sv
tb/tb_top.sv
